// ===== hdl/dsg_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the DDS generator.
// No dependencies; every other file uses this package.
package dsg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 8;
  localparam int CHANNEL_COUNT   = 2;

  localparam int SINE_QUARTER = 1 << SINE_TABLE_BITS;
  localparam int ENTRY_W      = 15;
  localparam int CODE_W       = 8;
  localparam int STEP_W       = 32;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] SINE_PEAK = 64'd32767;
  localparam logic [63:0] HALF_Q30  = 64'd536870912;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE_CH0   = 3'd0;
  localparam logic [2:0] REG_MODE_CH1   = 3'd1;
  localparam logic [2:0] REG_STEP_CH0   = 3'd2;
  localparam logic [2:0] REG_STEP_CH1   = 3'd3;
  localparam logic [2:0] REG_AMP_CH0    = 3'd4;
  localparam logic [2:0] REG_AMP_CH1    = 3'd5;
  localparam logic [2:0] REG_OFFSET_CH0 = 3'd6;
  localparam logic [2:0] REG_OFFSET_CH1 = 3'd7;

  localparam logic MODE_SINE = 1'b0;

  localparam logic [STEP_W-1:0] STEP_RST   = 32'd4294967;
  localparam logic [CODE_W-1:0] AMP_RST    = 8'd77;
  localparam logic [CODE_W-1:0] OFFSET_RST = 8'd128;

  typedef struct packed {
    logic [1:0]              mode;
    logic [1:0][STEP_W-1:0]  step;
    logic [1:0][CODE_W-1:0]  amp;
    logic [1:0][CODE_W-1:0]  offset;
  } dsg_cfg_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic                  channel;
    logic                  mode;
    logic [CODE_W-1:0]     amp;
    logic [CODE_W-1:0]     offset;
  } dsg_stage_t;

  typedef logic [ENTRY_W-1:0] sine_lut_t [SINE_QUARTER];

  // Q30 Taylor series of sin at the centre of quarter-wave slot k, up to x^11
  function automatic logic [ENTRY_W-1:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] scaled;
    longint      s;
    // divide by four quarter-table sizes: a power of two
    x = (PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (SINE_TABLE_BITS + 2);
    term = x;
    s = longint'(x);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd6;
    s = s - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd20;
    s = s + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd42;
    s = s - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd72;
    s = s + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd110;
    s = s - longint'(term);
    if (s < 0) s = 0;
    scaled = (64'(s) * SINE_PEAK + HALF_Q30) >> 30;
    if (scaled > SINE_PEAK) scaled = SINE_PEAK;
    return scaled[ENTRY_W-1:0];
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int k = 0; k < SINE_QUARTER; k++) begin
      lut[k] = sine_entry(k);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// ===== hdl/dsg_if.sv =====
// Valid/ready stream interfaces for sample ticks and DAC results.
// Depends on dsg_pkg for the code width.
interface dsg_in_if;
  logic valid;
  logic ready;
  logic channel;
  modport source (output valid, output channel, input ready);
  modport sink   (input valid, input channel, output ready);
endinterface

interface dsg_out_if;
  logic                      valid;
  logic                      ready;
  logic [dsg_pkg::CODE_W-1:0] sample_code;
  logic                      sample_channel;
  logic                      clipped;
  modport source (output valid, output sample_code, output sample_channel, output clipped,
                  input ready);
  modport sink   (input valid, input sample_code, input sample_channel, input clipped,
                  output ready);
endinterface

// ===== hdl/dds_sine_sawtooth_generator.sv =====
// Two-channel DDS sine/sawtooth generator, top level.
// Path from the accepting edge to the result beat: phase register, then result register.
// Throughput: one beat per cycle, set by the phase register stage and the
// lookup-and-multiply result stage; a stalled output holds both stages.
// Reset (rst_n low, synchronous): phases cleared, registers to reset values,
// pipeline emptied.
module dds_sine_sawtooth_generator import dsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dsg_in_if.sink            in_chan,
  dsg_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  dsg_cfg_t   cfg;
  logic       stage_adv;
  logic       stage_valid;
  dsg_stage_t stage_data;

  dsg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsg_phase_stage u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_chan     (in_chan),
    .stage_adv   (stage_adv),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  dsg_wave_stage u_wave (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_data  (stage_data),
    .stage_adv   (stage_adv),
    .out_chan    (out_chan)
  );

endmodule

// ===== hdl/dsg_cfg_regs.sv =====
// APB-style register file holding mode, step, amplitude and offset per channel.
// Depends on dsg_pkg.
module dsg_cfg_regs import dsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output dsg_cfg_t          cfg
);

  dsg_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= '0;
      cfg_r.step   <= {STEP_RST, STEP_RST};
      cfg_r.amp    <= {AMP_RST, AMP_RST};
      cfg_r.offset <= {OFFSET_RST, OFFSET_RST};
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE_CH0:   cfg_r.mode[0]   <= pwdata[0];
        REG_MODE_CH1:   cfg_r.mode[1]   <= pwdata[0];
        REG_STEP_CH0:   cfg_r.step[0]   <= pwdata[STEP_W-1:0];
        REG_STEP_CH1:   cfg_r.step[1]   <= pwdata[STEP_W-1:0];
        REG_AMP_CH0:    cfg_r.amp[0]    <= pwdata[CODE_W-1:0];
        REG_AMP_CH1:    cfg_r.amp[1]    <= pwdata[CODE_W-1:0];
        REG_OFFSET_CH0: cfg_r.offset[0] <= pwdata[CODE_W-1:0];
        REG_OFFSET_CH1: cfg_r.offset[1] <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE_CH0:   prdata = DATA_W'(cfg_r.mode[0]);
      REG_MODE_CH1:   prdata = DATA_W'(cfg_r.mode[1]);
      REG_STEP_CH0:   prdata = DATA_W'(cfg_r.step[0]);
      REG_STEP_CH1:   prdata = DATA_W'(cfg_r.step[1]);
      REG_AMP_CH0:    prdata = DATA_W'(cfg_r.amp[0]);
      REG_AMP_CH1:    prdata = DATA_W'(cfg_r.amp[1]);
      REG_OFFSET_CH0: prdata = DATA_W'(cfg_r.offset[0]);
      REG_OFFSET_CH1: prdata = DATA_W'(cfg_r.offset[1]);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hdl/dsg_phase_stage.sv =====
// Input register stage: per-channel phase accumulators and capture of the
// channel's settings. Depends on dsg_pkg and dsg_in_if.
module dsg_phase_stage import dsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dsg_cfg_t   cfg,
  dsg_in_if.sink     in_chan,
  input  logic       stage_adv,
  output logic       stage_valid,
  output dsg_stage_t stage_data
);

  logic [PHASE_BITS-1:0] phase_r [CHANNEL_COUNT];
  logic [PHASE_BITS-1:0] phase_nxt;
  logic                  stage_valid_r;
  dsg_stage_t            stage_r;
  dsg_stage_t            stage_nxt;
  logic                  load;
  logic                  take;
  logic                  ch;

  assign ch    = in_chan.channel;
  assign load  = !stage_valid_r || stage_adv;
  assign in_chan.ready = load;
  // drop ticks for channels that have no accumulator
  assign take  = in_chan.valid && load && (32'(ch) < 32'(CHANNEL_COUNT));

  assign phase_nxt = phase_r[ch] + PHASE_BITS'(cfg.step[ch]);

  always_comb begin
    stage_nxt.phase   = phase_nxt;
    stage_nxt.channel = ch;
    stage_nxt.mode    = cfg.mode[ch];
    stage_nxt.amp     = cfg.amp[ch];
    stage_nxt.offset  = cfg.offset[ch];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        phase_r[i] <= '0;
      end
    end else begin
      if (load) stage_valid_r <= take;
      if (take) phase_r[ch] <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) stage_r <= stage_nxt;
  end

  assign stage_valid = stage_valid_r;
  assign stage_data  = stage_r;

endmodule

// ===== hdl/dsg_wave_stage.sv =====
// Waveform stage: quarter-wave sine lookup or sawtooth ramp, scaling,
// saturation and the result register. Depends on dsg_pkg and dsg_out_if.
module dsg_wave_stage import dsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       stage_valid,
  input  dsg_stage_t stage_data,
  output logic       stage_adv,
  dsg_out_if.source  out_chan
);

  localparam int P_W = SINE_TABLE_BITS + 2;
  localparam int SIN_PROD_W = CODE_W + ENTRY_W;
  localparam int SAW_PROD_W = CODE_W + PHASE_BITS;

  logic [P_W-1:0]             p;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [ENTRY_W-1:0]         entry;
  logic [SIN_PROD_W-1:0]      sin_sum;
  logic [CODE_W-1:0]          r;
  logic [SAW_PROD_W-1:0]      saw_prod;
  logic [CODE_W:0]            ramp;
  logic signed [10:0]         value;
  logic [CODE_W-1:0]          code_nxt;
  logic                       clip_nxt;

  logic                       out_valid_r;
  logic [CODE_W-1:0]          code_r;
  logic                       ch_r;
  logic                       clip_r;

  assign stage_adv = !out_valid_r || out_chan.ready;

  always_comb begin
    p     = stage_data.phase[PHASE_BITS-1 -: P_W];
    quad  = p[P_W-1 -: 2];
    k     = p[SINE_TABLE_BITS-1:0];
    // mirror the index on the falling quarters
    if (quad[0]) k = ~k;
    entry   = SINE_LUT[k];
    sin_sum = SIN_PROD_W'(stage_data.amp) * SIN_PROD_W'(entry) + SIN_PROD_W'(16384);
    r       = sin_sum[SIN_PROD_W-1 -: CODE_W];
    saw_prod = SAW_PROD_W'(stage_data.amp) * SAW_PROD_W'(stage_data.phase);
    ramp     = saw_prod[SAW_PROD_W-1 -: CODE_W+1];

    if (stage_data.mode == MODE_SINE) begin
      if (quad[1]) value = $signed({3'b000, stage_data.offset}) - $signed({3'b000, r});
      else         value = $signed({3'b000, stage_data.offset}) + $signed({3'b000, r});
    end else begin
      value = $signed({3'b000, stage_data.offset}) - $signed({3'b000, stage_data.amp})
            + $signed({2'b00, ramp});
    end

    if (value < 0) begin
      code_nxt = '0;
      clip_nxt = 1'b1;
    end else if (value > 11'sd255) begin
      code_nxt = '1;
      clip_nxt = 1'b1;
    end else begin
      code_nxt = value[CODE_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_adv) begin
      out_valid_r <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_valid) begin
      code_r <= code_nxt;
      ch_r   <= stage_data.channel;
      clip_r <= clip_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.sample_code    = code_r;
  assign out_chan.sample_channel = ch_r;
  assign out_chan.clipped        = clip_r;

endmodule
